### hdl/dqp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants for the DNS query question parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

    localparam int MAX_NAME    = 253;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int OUT_DATA_W  = 64;

    localparam logic [3:0] HDR_LAST_POS = 4'd11;

    // verdict status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT_HDR = 4'd1;
    localparam logic [3:0] ST_BAD_HDR   = 4'd2;
    localparam logic [3:0] ST_TRUNC     = 4'd3;
    localparam logic [3:0] ST_BAD_LABEL = 4'd4;
    localparam logic [3:0] ST_TOO_LONG  = 4'd5;
    localparam logic [3:0] ST_BAD_CHAR  = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_BAD_CLASS = 4'd8;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0]  CH_DOT      = 8'h2E;
    localparam logic [15:0] CLASS_IN    = 16'h0001;
    localparam logic [5:0]  TAIL_BYTES  = 6'd4;
    localparam logic [8:0]  QLEN_EXTRA  = 9'd6;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_LABEL,
        PH_TAIL,
        PH_DONE
    } phase_t;

    // one classified packet byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
        logic       len_bad;   // pointer bits or length above 63
        logic       char_ok;   // printable, 0x21..0x7E
        logic [7:0] lower;
    } byte_info_t;

    typedef struct packed {
        logic       valid;
        byte_info_t info;
    } push_t;

    typedef struct packed {
        logic       valid;
        byte_info_t info;
    } head_t;

endpackage

`default_nettype wire

### hdl/dqp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqp_front
// Accepts packet bytes and tags each with the checks the parser needs.
// ----------------------------------------------------------------------------
module dqp_front (
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tlast,
    input  wire logic            q_full,
    output dqp_pkg::push_t       push
);

    logic [7:0] b;

    assign b        = s_tdata;
    assign s_tready = !q_full;

    always_comb begin
        push.valid        = s_tvalid && !q_full;
        push.info.data    = b;
        push.info.last    = s_tlast;
        push.info.is_zero = (b == 8'h00);
        push.info.len_bad = (b > 8'd63);
        push.info.char_ok = (b > 8'h20) && (b < 8'h7F);
        push.info.lower   = (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
    end

endmodule

`default_nettype wire

### hdl/dqp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqp_fifo
// Short queue of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
module dqp_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire dqp_pkg::push_t  push,
    output logic                 full,
    output dqp_pkg::head_t       head,
    input  wire logic            pop
);

    dqp_pkg::byte_info_t             mem_reg [dqp_pkg::FIFO_DEPTH];
    logic [dqp_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dqp_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dqp_pkg::FIFO_AW:0]       count_reg, count_next;
    logic                            do_pop;

    assign full       = (count_reg == (dqp_pkg::FIFO_AW+1)'(dqp_pkg::FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.info  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.info;
        end
    end

endmodule

`default_nettype wire

### hdl/dqp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqp_back
// Header/label/tail parser and output register for characters and verdicts.
// ----------------------------------------------------------------------------
module dqp_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dqp_pkg::head_t                    head,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dqp_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tuser
);

    dqp_pkg::phase_t phase_reg, phase_next, phase_calc;
    logic [3:0]  hdr_pos_reg, hdr_pos_next;
    logic [15:0] id_reg, id_next;
    logic        rd_reg, rd_next;
    logic [5:0]  rem_reg, rem_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] class_reg, class_next;
    logic [3:0]  error_reg, error_next;
    logic [3:0]  err_code;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_user_reg, out_user_next;
    logic [dqp_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    dqp_pkg::byte_info_t bi;
    logic        step;
    logic        emit;
    logic [7:0]  ch;
    logic        too_long;
    logic [3:0]  st;

    assign bi       = head.info;
    assign pop      = head.valid && (!out_valid_reg || m_tready);
    assign step     = pop;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // dot plus label must fit in the name budget
    assign too_long = ({1'b0, count_reg} + {8'd0, (count_reg != 8'd0)} + {1'b0, bi.data})
                      > 9'(dqp_pkg::MAX_NAME);

    // error raised by this byte, if any
    always_comb begin
        err_code = dqp_pkg::ST_OK;
        case (phase_reg)
            dqp_pkg::PH_HEADER: begin
                if ((hdr_pos_reg == 4'd2 && bi.data[7:3] != 5'd0) ||
                    (hdr_pos_reg == 4'd4 && bi.data != 8'h00) ||
                    (hdr_pos_reg == 4'd5 && bi.data != 8'h01)) begin
                    err_code = dqp_pkg::ST_BAD_HDR;
                end
            end
            dqp_pkg::PH_LEN: begin
                if (bi.is_zero) begin
                    if (count_reg == 8'd0) err_code = dqp_pkg::ST_EMPTY;
                end else if (bi.len_bad) begin
                    err_code = dqp_pkg::ST_BAD_LABEL;
                end else if (too_long) begin
                    err_code = dqp_pkg::ST_TOO_LONG;
                end
            end
            dqp_pkg::PH_LABEL: begin
                if (!bi.char_ok) err_code = dqp_pkg::ST_BAD_CHAR;
            end
            dqp_pkg::PH_TAIL: begin
                if (rem_reg == 6'd1 && {class_reg[7:0], bi.data} != dqp_pkg::CLASS_IN) begin
                    err_code = dqp_pkg::ST_BAD_CLASS;
                end
            end
            default: err_code = dqp_pkg::ST_OK;
        endcase
    end

    assign error_next = (error_reg != dqp_pkg::ST_OK) ? error_reg : err_code;

    // next state
    always_comb begin
        phase_calc = phase_reg;
        case (phase_reg)
            dqp_pkg::PH_HEADER: begin
                if (hdr_pos_reg >= dqp_pkg::HDR_LAST_POS) begin
                    phase_calc = (error_next != dqp_pkg::ST_OK) ? dqp_pkg::PH_DONE
                                                                : dqp_pkg::PH_LEN;
                end
            end
            dqp_pkg::PH_LEN: begin
                if (bi.is_zero) begin
                    phase_calc = (count_reg == 8'd0) ? dqp_pkg::PH_DONE : dqp_pkg::PH_TAIL;
                end else if (bi.len_bad) begin
                    phase_calc = dqp_pkg::PH_DONE;
                end else begin
                    phase_calc = dqp_pkg::PH_LABEL;
                end
            end
            dqp_pkg::PH_LABEL: begin
                if (rem_reg == 6'd1) begin
                    phase_calc = (error_next != dqp_pkg::ST_OK) ? dqp_pkg::PH_DONE
                                                                : dqp_pkg::PH_LEN;
                end
            end
            dqp_pkg::PH_TAIL: begin
                if (rem_reg == 6'd1) phase_calc = dqp_pkg::PH_DONE;
            end
            default: phase_calc = dqp_pkg::PH_DONE;
        endcase
        phase_next = bi.last ? dqp_pkg::PH_HEADER : phase_calc;
    end

    // datapath and result
    always_comb begin
        hdr_pos_next = hdr_pos_reg;
        id_next      = id_reg;
        rd_next      = rd_reg;
        rem_next     = rem_reg;
        type_next    = type_reg;
        class_next   = class_reg;
        emit         = 1'b0;
        ch           = 8'h00;

        case (phase_reg)
            dqp_pkg::PH_HEADER: begin
                hdr_pos_next = hdr_pos_reg + 4'd1;
                if (hdr_pos_reg < 4'd2) id_next = {id_reg[7:0], bi.data};
                if (hdr_pos_reg == 4'd2) rd_next = bi.data[0];
            end
            dqp_pkg::PH_LEN: begin
                if (bi.is_zero) begin
                    rem_next = dqp_pkg::TAIL_BYTES;
                end else if (!bi.len_bad) begin
                    rem_next = bi.data[5:0];
                    if (!too_long && count_reg != 8'd0) begin
                        emit = 1'b1;
                        ch   = dqp_pkg::CH_DOT;
                    end
                end
            end
            dqp_pkg::PH_LABEL: begin
                if (error_reg == dqp_pkg::ST_OK && bi.char_ok) begin
                    emit = 1'b1;
                    ch   = bi.lower;
                end
                rem_next = rem_reg - 6'd1;
            end
            dqp_pkg::PH_TAIL: begin
                if (rem_reg > 6'd2) type_next  = {type_reg[7:0], bi.data};
                else                class_next = {class_reg[7:0], bi.data};
                rem_next = rem_reg - 6'd1;
            end
            default: ;
        endcase

        count_next = emit ? count_reg + 8'd1 : count_reg;

        if (phase_calc == dqp_pkg::PH_HEADER)     st = dqp_pkg::ST_SHORT_HDR;
        else if (phase_calc == dqp_pkg::PH_DONE)  st = error_next;
        else                                      st = dqp_pkg::ST_TRUNC;

        out_valid_next = out_valid_reg && !m_tready;
        out_user_next  = out_user_reg;
        out_data_next  = out_data_reg;
        if (step && bi.last) begin
            out_valid_next = 1'b1;
            out_user_next  = dqp_pkg::KIND_VERDICT;
            out_data_next  = '0;
            out_data_next[11:8] = st;
            if (st == dqp_pkg::ST_OK) begin
                out_data_next[27:12] = id_next;
                out_data_next[43:28] = type_next;
                out_data_next[44]    = rd_next;
                out_data_next[52:45] = count_next;
                out_data_next[61:53] = {1'b0, count_next} + dqp_pkg::QLEN_EXTRA;
            end
        end else if (step && emit) begin
            out_valid_next     = 1'b1;
            out_user_next      = dqp_pkg::KIND_CHAR;
            out_data_next      = '0;
            out_data_next[7:0] = ch;
        end

        // end of packet returns everything to the header state
        if (bi.last) begin
            hdr_pos_next = '0;
            id_next      = '0;
            rd_next      = 1'b0;
            rem_next     = '0;
            count_next   = '0;
            type_next    = '0;
            class_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dqp_pkg::PH_HEADER;
            hdr_pos_reg   <= '0;
            id_reg        <= '0;
            rd_reg        <= 1'b0;
            rem_reg       <= '0;
            count_reg     <= '0;
            type_reg      <= '0;
            class_reg     <= '0;
            error_reg     <= dqp_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                hdr_pos_reg <= hdr_pos_next;
                id_reg      <= id_next;
                rd_reg      <= rd_next;
                rem_reg     <= rem_next;
                count_reg   <= count_next;
                type_reg    <= type_next;
                class_reg   <= class_next;
                error_reg   <= bi.last ? dqp_pkg::ST_OK : error_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_user_reg <= out_user_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### hdl/dns_query_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_parser_top
// Streaming DNS query question parser: header checks, name walk, verdict.
//
//   channel   dir   payload
//   s_        in    tdata[7:0] packet byte, tlast final byte
//   m_        out   tuser kind, tdata name char / verdict fields
//
// One byte per clock sustained while m_ accepts every output. A byte passes the
// front classifier into a four-word queue; the parser takes one word per cycle
// whenever its output register is empty or being drained, and registers any
// character or verdict that the byte yields in that output register.
// Back-pressure on m_ fills the queue before s_tready drops. Synchronous
// active-low reset returns to the header state.
// ----------------------------------------------------------------------------
module dns_query_parser_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] name_char, [11:8] status, [27:12] query_id, [43:28] query_type,
    // [44] recursion_desired, [52:45] name_length, [61:53] question_length
    output logic [63:0]       m_tdata,
    output logic              m_tuser    // kind
);

    dqp_pkg::push_t push;
    dqp_pkg::head_t head;
    logic           q_full;
    logic           pop;

    dqp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push)
    );

    dqp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    dqp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
